// ===== rtl/lbfd_pkg.sv =====
// lbfd_pkg: shared constants, types and register codes of the LDPC bit-flipping decoder.
// Used by lbfd_cell and ldpc_bit_flip_decoder; depends on nothing.
package lbfd_pkg;

    localparam int CODE_BITS    = 15;
    localparam int CHECK_COUNT  = 9;
    localparam int MAX_ROUNDS   = 15;
    localparam int ROWS_PER_REG = 3;
    localparam int ROW_REGS     = 3;
    localparam int ROW_REG_W    = 45;
    localparam int THR_W        = 4;
    localparam int RND_W        = 4;
    localparam int CNT_W        = $clog2(CHECK_COUNT + 1);
    localparam int CHK_W        = $clog2(CHECK_COUNT);
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 45;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS    = 3'd4;

    localparam logic [ROW_REG_W-1:0] RST_ROWS_A    = 45'd34084892966943;
    localparam logic [ROW_REG_W-1:0] RST_ROWS_B    = 45'd0;
    localparam logic [ROW_REG_W-1:0] RST_ROWS_C    = 45'd0;
    localparam logic [THR_W-1:0]     RST_THRESHOLD = 4'd1;
    localparam logic [RND_W-1:0]     RST_ROUNDS    = 4'd10;
    localparam logic [RND_W-1:0]     ROUND_CAP     = RND_W'(MAX_ROUNDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;   // take the received bit, clear the count
        logic acc;    // add this check's failure to the count
        logic apply;  // last check of a round: flip and clear
    } t_cell_ctl;

endpackage

// ===== rtl/lbfd_cell.sv =====
// lbfd_cell: one code bit of the decoder: holds the bit and its failed-check count.
// Passes check parity and the any-flip flag to the next cell. Depends on lbfd_pkg.
module lbfd_cell (
    input  logic                     i_clk,
    input  lbfd_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_rx_bit,
    input  logic                     i_row_bit,
    input  logic                     i_fail,
    input  logic [lbfd_pkg::THR_W-1:0] i_thr,
    input  logic                     i_par,
    output logic                     o_par,
    input  logic                     i_any,
    output logic                     o_any,
    output logic                     o_bit
);

    logic                        r_bit;
    logic [lbfd_pkg::CNT_W-1:0]  r_cnt;
    logic [lbfd_pkg::CNT_W-1:0]  n_cnt;
    logic                        w_flip;

    assign n_cnt  = r_cnt + lbfd_pkg::CNT_W'(i_row_bit & i_fail);
    assign w_flip = i_ctl.apply & (n_cnt > lbfd_pkg::CNT_W'(i_thr));
    assign o_par  = i_par ^ (i_row_bit & r_bit);
    assign o_any  = i_any | w_flip;
    assign o_bit  = r_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_bit <= i_rx_bit;
            r_cnt <= '0;
        end else if (i_ctl.apply) begin
            r_bit <= r_bit ^ w_flip;
            r_cnt <= '0;
        end else if (i_ctl.acc) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/ldpc_bit_flip_decoder.sv =====
// ldpc_bit_flip_decoder: hard-decision LDPC bit-flipping decoder, top level.
// Depends on lbfd_pkg and lbfd_cell (one cell per code bit).
//
// Usage:
//   Input: drive i_received_word and pulse i_start while o_busy is low; the
//   item is taken at that clock edge and o_busy rises on the next cycle.
//   Output: o_valid is high for exactly one cycle with o_decoded_word; the
//   receiver has no way to stall and must take it then.
//   Config: i_cfg_we, i_cfg_index, i_cfg_data write a register at the edge
//   (0..2 check rows, 3 flip threshold, 4 round limit); other indexes are
//   ignored. Write only while o_busy is low.
// Operation:
//   Each round sweeps the CHECK_COUNT (9) checks one per cycle through the cell
//   row. Rounds run until one makes no flips or the round limit is reached;
//   o_valid is then raised from ST_DONE, and the next item is taken only once
//   the decoder has returned to idle after that.
// Reset:
//   i_rst_n low (synchronous) returns to idle, drops o_valid and loads the
//   register reset values; an item in progress is dropped.
module ldpc_bit_flip_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [lbfd_pkg::CODE_BITS-1:0]     i_received_word,
    output logic                               o_valid,
    output logic [lbfd_pkg::CODE_BITS-1:0]     o_decoded_word,
    input  logic                               i_cfg_we,
    input  logic [lbfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbfd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [lbfd_pkg::ROW_REG_W-1:0] r_rows [lbfd_pkg::ROW_REGS];
    logic [lbfd_pkg::THR_W-1:0]     r_thr;
    logic [lbfd_pkg::RND_W-1:0]     r_limit;

    lbfd_pkg::t_state               r_state, n_state;
    logic [lbfd_pkg::CHK_W-1:0]     r_chk, n_chk;
    logic [lbfd_pkg::RND_W-1:0]     r_round, n_round;
    logic [lbfd_pkg::RND_W-1:0]     w_limit;
    lbfd_pkg::t_cell_ctl            w_ctl;

    logic [lbfd_pkg::CODE_BITS-1:0] w_rows [lbfd_pkg::CHECK_COUNT];
    logic [lbfd_pkg::CODE_BITS-1:0] w_row;
    logic [lbfd_pkg::CODE_BITS:0]   w_par;
    logic [lbfd_pkg::CODE_BITS:0]   w_any;
    logic [lbfd_pkg::CODE_BITS-1:0] w_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= lbfd_pkg::RST_ROWS_A;
            r_rows[1] <= lbfd_pkg::RST_ROWS_B;
            r_rows[2] <= lbfd_pkg::RST_ROWS_C;
            r_thr     <= lbfd_pkg::RST_THRESHOLD;
            r_limit   <= lbfd_pkg::RST_ROUNDS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lbfd_pkg::REG_ROWS_A:    r_rows[0] <= i_cfg_data[lbfd_pkg::ROW_REG_W-1:0];
                lbfd_pkg::REG_ROWS_B:    r_rows[1] <= i_cfg_data[lbfd_pkg::ROW_REG_W-1:0];
                lbfd_pkg::REG_ROWS_C:    r_rows[2] <= i_cfg_data[lbfd_pkg::ROW_REG_W-1:0];
                lbfd_pkg::REG_THRESHOLD: r_thr     <= i_cfg_data[lbfd_pkg::THR_W-1:0];
                lbfd_pkg::REG_ROUNDS:    r_limit   <= i_cfg_data[lbfd_pkg::RND_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_limit = (r_limit > lbfd_pkg::ROUND_CAP) ? lbfd_pkg::ROUND_CAP : r_limit;

    // unpack check rows
    for (genvar r = 0; r < lbfd_pkg::CHECK_COUNT; r++) begin : g_rows
        assign w_rows[r] = r_rows[r / lbfd_pkg::ROWS_PER_REG]
            [(r % lbfd_pkg::ROWS_PER_REG) * lbfd_pkg::CODE_BITS +: lbfd_pkg::CODE_BITS];
    end
    assign w_row = w_rows[r_chk];

    // cell row
    assign w_par[0] = 1'b0;
    assign w_any[0] = 1'b0;
    for (genvar b = 0; b < lbfd_pkg::CODE_BITS; b++) begin : g_cells
        lbfd_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_rx_bit  (i_received_word[b]),
            .i_row_bit (w_row[b]),
            .i_fail    (w_par[lbfd_pkg::CODE_BITS]),
            .i_thr     (r_thr),
            .i_par     (w_par[b]),
            .o_par     (w_par[b+1]),
            .i_any     (w_any[b]),
            .o_any     (w_any[b+1]),
            .o_bit     (w_word[b])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbfd_pkg::ST_IDLE;
            r_chk   <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
            r_round <= n_round;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_chk          = r_chk;
        n_round        = r_round;
        w_ctl          = '0;
        o_busy         = 1'b1;
        o_valid        = 1'b0;
        unique case (r_state)
            lbfd_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    w_ctl.load = 1'b1;
                    n_chk      = '0;
                    n_round    = '0;
                    n_state    = (w_limit == '0) ? lbfd_pkg::ST_DONE : lbfd_pkg::ST_RUN;
                end
            end
            lbfd_pkg::ST_RUN: begin
                w_ctl.acc = 1'b1;
                if (r_chk == lbfd_pkg::CHK_W'(lbfd_pkg::CHECK_COUNT - 1)) begin
                    w_ctl.apply = 1'b1;
                    n_chk       = '0;
                    n_round     = r_round + lbfd_pkg::RND_W'(1);
                    if (!w_any[lbfd_pkg::CODE_BITS] || n_round == w_limit) begin
                        n_state = lbfd_pkg::ST_DONE;
                    end
                end else begin
                    n_chk = r_chk + lbfd_pkg::CHK_W'(1);
                end
            end
            lbfd_pkg::ST_DONE: begin
                o_valid = 1'b1;
                n_state = lbfd_pkg::ST_IDLE;
            end
            default: n_state = lbfd_pkg::ST_IDLE;
        endcase
    end

    assign o_decoded_word = w_word;

`ifndef ASSERT_OFF
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");
    a_chk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk <= lbfd_pkg::CHK_W'(lbfd_pkg::CHECK_COUNT - 1))
        else $error("check index out of range");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbfd_pkg::ST_RUN) |-> (r_round < w_limit))
        else $error("round count past limit");
    a_valid_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == lbfd_pkg::ST_RUN || $past(r_state) == lbfd_pkg::ST_IDLE))
        else $error("result without preceding work");
`endif

endmodule
